>>> hw/rtl/cssd_pkg.sv
// ----------------------------------------------------------------------------
// Colour symbol signal decoder package
// Shared constants, colour codes, register indexes and the signal table.
// ----------------------------------------------------------------------------
package cssd_pkg;

  // default values for the top level parameters
  localparam int unsigned NUM_SIGNALS_DEF = 6;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // number of entries in the signal table
  localparam int unsigned MAX_SIGNALS = 6;

  // configuration register file
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_COUNT = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RED_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LOW  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_HIGH = 3'd7;

  // register reset values, in index order
  typedef logic [CFG_W-1:0] cfg_word_t;
  localparam cfg_word_t CFG_RESET [CFG_COUNT] = '{
    10'd885, 10'd905, 10'd845, 10'd860, 10'd800, 10'd825, 10'd55, 10'd75
  };

  // colour band of a sample
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_RED   = 3'd1,
    CLS_GREEN = 3'd2,
    CLS_BLUE  = 3'd3,
    CLS_WHITE = 3'd4
  } colour_e;

  // stored symbol: 0 empty, 1 red, 2 green, 3 blue
  typedef logic [1:0] symbol_t;
  localparam symbol_t SYM_NONE  = 2'd0;
  localparam symbol_t SYM_RED   = 2'd1;
  localparam symbol_t SYM_GREEN = 2'd2;
  localparam symbol_t SYM_BLUE  = 2'd3;

  typedef symbol_t pattern_t [3];

  // signal n is entry n-1
  localparam pattern_t SIGNAL_TABLE [MAX_SIGNALS] = '{
    '{SYM_RED,   SYM_BLUE,  SYM_GREEN},
    '{SYM_RED,   SYM_GREEN, SYM_BLUE},
    '{SYM_BLUE,  SYM_RED,   SYM_GREEN},
    '{SYM_BLUE,  SYM_GREEN, SYM_RED},
    '{SYM_GREEN, SYM_RED,   SYM_BLUE},
    '{SYM_GREEN, SYM_BLUE,  SYM_RED}
  };

  // result word, highest field first
  typedef struct packed {
    logic       pattern_error;
    logic [2:0] signal_number;
    logic       signal_valid;
    logic [2:0] colour_class;
  } result_t;

endpackage

>>> hw/rtl/colour_symbol_signal_decoder.sv
// ----------------------------------------------------------------------------
// Colour symbol signal decoder
// Classifies sensor samples into colour bands, collects three-colour symbol
// runs and decodes them into one of the known signals.
// ----------------------------------------------------------------------------
// An accepted word's result is registered in the output register, or in the
// skid register while the output waits, so input is taken while a result
// waits. Throughput: one word per cycle while the skid register is empty;
// classify and match sit between the symbol state and result registers.
// Reset: rst_ni clears the symbol store, fill count, last colour and valid
// flags and loads the band registers with their default bounds.
module colour_symbol_signal_decoder #(
  parameter int unsigned NUM_SIGNALS = cssd_pkg::NUM_SIGNALS_DEF,
  parameter int unsigned SAMPLE_BITS = cssd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [cssd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [cssd_pkg::CFG_W-1:0]            cfg_wdata_i,
  // sample stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // fields: raw_sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // fields: colour_class[2:0], signal_valid[3], signal_number[6:4],
  // pattern_error[7]
  output logic [7:0]                            m_axis_tdata
);

  import cssd_pkg::*;

  localparam int unsigned CmpW = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam logic [CFG_W-1:0] CfgMask =
    (SAMPLE_BITS >= CFG_W) ? {CFG_W{1'b1}} : CFG_W'((1 << SAMPLE_BITS) - 1);

  // band registers
  cfg_word_t cfg_q [CFG_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_COUNT; i++) cfg_q[i] <= CFG_RESET[i];
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RED_LOW:    cfg_q[0] <= cfg_wdata_i & CfgMask;
        CFG_RED_HIGH:   cfg_q[1] <= cfg_wdata_i & CfgMask;
        CFG_GREEN_LOW:  cfg_q[2] <= cfg_wdata_i & CfgMask;
        CFG_GREEN_HIGH: cfg_q[3] <= cfg_wdata_i & CfgMask;
        CFG_BLUE_LOW:   cfg_q[4] <= cfg_wdata_i & CfgMask;
        CFG_BLUE_HIGH:  cfg_q[5] <= cfg_wdata_i & CfgMask;
        CFG_WHITE_LOW:  cfg_q[6] <= cfg_wdata_i & CfgMask;
        CFG_WHITE_HIGH: cfg_q[7] <= cfg_wdata_i & CfgMask;
        default: ;
      endcase
    end
  end

  // symbol state
  symbol_t    slots_q [3];
  symbol_t    slots_d [3];
  logic [1:0] fill_q, fill_d;
  symbol_t    last_q, last_d;

  // result registers: output stage and skid stage
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  logic    accept;
  logic    out_take;
  result_t res;

  logic [CmpW-1:0] sample;
  logic [CmpW-1:0] bound [CFG_COUNT];
  logic            in_band [4];
  colour_e         cls;
  logic            full;
  logic [2:0]      number;
  logic [1:0]      eff_fill;
  symbol_t         eff_last;
  symbol_t         sym;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_take = out_valid_q && m_axis_tready;

  // band windows, all bounds exclusive
  always_comb begin
    sample = CmpW'(s_axis_tdata[SAMPLE_BITS-1:0]);
    for (int i = 0; i < CFG_COUNT; i++) bound[i] = CmpW'(cfg_q[i]);
    for (int b = 0; b < 4; b++) begin
      in_band[b] = (sample > bound[2*b]) && (sample < bound[2*b+1]);
    end
    if (in_band[0])      cls = CLS_RED;
    else if (in_band[1]) cls = CLS_GREEN;
    else if (in_band[2]) cls = CLS_BLUE;
    else if (in_band[3]) cls = CLS_WHITE;
    else                 cls = CLS_NONE;
  end

  // pattern match against the first NUM_SIGNALS table entries
  always_comb begin
    number = 3'd0;
    for (int i = MAX_SIGNALS - 1; i >= 0; i--) begin
      if (i < NUM_SIGNALS && slots_q[0] == SIGNAL_TABLE[i][0] &&
          slots_q[1] == SIGNAL_TABLE[i][1] && slots_q[2] == SIGNAL_TABLE[i][2]) begin
        number = 3'(i + 1);
      end
    end
  end

  // next symbol state and result word
  always_comb begin
    full     = (fill_q == 2'd3);
    eff_fill = full ? 2'd0 : fill_q;
    eff_last = full ? SYM_NONE : last_q;
    sym      = cls[1:0];
    for (int i = 0; i < 3; i++) slots_d[i] = full ? SYM_NONE : slots_q[i];
    fill_d = eff_fill;
    last_d = eff_last;
    if (cls == CLS_RED || cls == CLS_GREEN || cls == CLS_BLUE) begin
      if (sym != eff_last) begin
        slots_d[eff_fill] = sym;
        fill_d            = eff_fill + 2'd1;
      end
      last_d = sym;
    end
    res.colour_class  = cls;
    res.signal_valid  = full && (number != 3'd0);
    res.signal_number = full ? number : 3'd0;
    res.pattern_error = full && (number == 3'd0);
  end

  // symbol state advances once per accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) slots_q[i] <= SYM_NONE;
      fill_q <= 2'd0;
      last_q <= SYM_NONE;
    end else if (accept) begin
      for (int i = 0; i < 3; i++) slots_q[i] <= slots_d[i];
      fill_q <= fill_d;
      last_q <= last_d;
    end
  end

  // output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (accept) begin
        if (out_valid_q && !m_axis_tready) skid_valid_q <= 1'b1;
        else                               out_valid_q  <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) out_q <= skid_q;
    end else if (accept) begin
      if (out_valid_q && !m_axis_tready) skid_q <= res;
      else                               out_q  <= res;
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // a full store is always cleared by the next accepted word, which may store one new symbol
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && fill_q == 2'd3) |=> (fill_q <= 2'd1))
    else $error("symbol store not cleared after match");

  // a held result never reports both a signal and an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.signal_valid && out_q.pattern_error))
    else $error("signal and pattern error both set");

  // the skid stage is only used behind a waiting output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while output is empty");

  // a stalled output word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule
